// ===== sv/vrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrsp_pkg
// Shared constants, request and command codes, and the item and register
// types of the variable-rate sample player.
// ----------------------------------------------------------------------------
package vrsp_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int FRAC_BITS   = 16;
  localparam int MEM_AW      = $clog2(STORE_DEPTH);

  localparam int REQ_W     = 3;
  localparam int ADDR_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int SPEED_W   = 24;
  localparam int COUNT_W   = 17;
  localparam int POS_W     = COUNT_W + 1 + FRAC_BITS;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PLAY  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PAUSE = 3'd4;

  localparam logic [1:0] REG_SPEED   = 2'd0;
  localparam logic [1:0] REG_LOOPING = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;
  localparam logic [1:0] REG_LOADED  = 2'd3;

  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(1) << FRAC_BITS;

  typedef enum logic [5:0] {
    CMD_TICK  = 6'b000001,
    CMD_WRITE = 6'b000010,
    CMD_PLAY  = 6'b000100,
    CMD_STOP  = 6'b001000,
    CMD_PAUSE = 6'b010000,
    CMD_NOP   = 6'b100000
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [ADDR_W-1:0]   address;
    logic [SAMPLE_W-1:0] sample_data;
    logic                pause_on;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               looping;
    logic [COUNT_W-1:0] sample_count;
    logic               loaded;
  } cfg_t;

endpackage

// ===== sv/vrsp_if.sv =====
// ----------------------------------------------------------------------------
// vrsp_if
// Valid/ready channel interfaces for request items and result items.
// ----------------------------------------------------------------------------
interface vrsp_in_if import vrsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [ADDR_W-1:0]          address;
  logic signed [SAMPLE_W-1:0] sample_data;
  logic                       pause_on;

  modport source (output valid, output req_type, output address, output sample_data,
                  output pause_on, input ready);
  modport sink (input valid, input req_type, input address, input sample_data,
                input pause_on, output ready);
endinterface

interface vrsp_out_if import vrsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       playing;
  logic                       finished;

  modport source (output valid, output sample_out, output playing, output finished,
                  input ready);
  modport sink (input valid, input sample_out, input playing, input finished,
                output ready);
endinterface

// ===== sv/vrsp_cfg.sv =====
// ----------------------------------------------------------------------------
// vrsp_cfg
// APB-style register file holding speed, looping, sample count and loaded.
// ----------------------------------------------------------------------------
module vrsp_cfg import vrsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed        <= SPEED_RESET;
      cfg_r.looping      <= 1'b0;
      cfg_r.sample_count <= '0;
      cfg_r.loaded       <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SPEED:   cfg_r.speed        <= pwdata[SPEED_W-1:0];
        REG_LOOPING: cfg_r.looping      <= pwdata[0];
        REG_COUNT:   cfg_r.sample_count <= pwdata[COUNT_W-1:0];
        REG_LOADED:  cfg_r.loaded       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPEED:   prdata = CFG_DW'(cfg_r.speed);
      REG_LOOPING: prdata = CFG_DW'(cfg_r.looping);
      REG_COUNT:   prdata = CFG_DW'(cfg_r.sample_count);
      REG_LOADED:  prdata = CFG_DW'(cfg_r.loaded);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== sv/vrsp_front.sv =====
// ----------------------------------------------------------------------------
// vrsp_front
// Accepts request items, decodes the request type into a command and holds
// the items in a short queue ahead of the playback engine.
// ----------------------------------------------------------------------------
module vrsp_front import vrsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  vrsp_in_if.sink   in_ch,
  output logic      q_vld,
  output item_t     q_item,
  input  logic      q_pop
);

  item_t              q_mem [0:Q_DEPTH-1];
  logic [Q_AW-1:0]    wr_ptr_r;
  logic [Q_AW-1:0]    rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic               push;
  item_t              dec_item;

  always_comb begin
    case (in_ch.req_type)
      REQ_TICK:  dec_item.cmd = CMD_TICK;
      REQ_WRITE: dec_item.cmd = CMD_WRITE;
      REQ_PLAY:  dec_item.cmd = CMD_PLAY;
      REQ_STOP:  dec_item.cmd = CMD_STOP;
      REQ_PAUSE: dec_item.cmd = CMD_PAUSE;
      default:   dec_item.cmd = CMD_NOP;
    endcase
    dec_item.address     = in_ch.address;
    dec_item.sample_data = in_ch.sample_data;
    dec_item.pause_on    = in_ch.pause_on;
  end

  assign in_ch.ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_vld       = (cnt_r != '0);
  assign q_item      = q_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (q_pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec_item;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("Queue popped while empty.");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("Queue count exceeds its depth.");

endmodule

// ===== sv/vrsp_back.sv =====
// ----------------------------------------------------------------------------
// vrsp_back
// Playback engine: issue stage updating position and play state, sample
// store read, interpolation multiply, rounding and saturation into the
// output register.
// ----------------------------------------------------------------------------
module vrsp_back import vrsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_vld,
  input  item_t      q_item,
  output logic       q_pop,
  vrsp_out_if.source out_ch
);

  localparam int IP_W   = POS_W - FRAC_BITS;
  localparam int IDX_W  = IP_W + 1;
  localparam int R_W    = FRAC_BITS + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = R_W + DIFF_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int QT_W   = ACC_W - FRAC_BITS;
  localparam logic [ACC_W-1:0]       HALF  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [QT_W-1:0] QT_HI = QT_W'(SAMPLE_MAX);
  localparam logic signed [QT_W-1:0] QT_LO = QT_W'(SAMPLE_MIN);

  logic signed [POS_W-1:0] pos_r;
  logic signed [POS_W-1:0] pos_nxt;
  logic                    playing_r;
  logic                    playing_nxt;
  logic                    paused_r;
  logic                    paused_nxt;

  logic                    x_vld_r;
  item_t                   x_item_r;
  logic signed [POS_W-1:0] x_sum_r;
  logic                    x_fire;
  logic                    x_neg;
  logic [POS_W-1:0]        x_mag;
  logic [IP_W-1:0]         x_ip_mag;
  logic [FRAC_BITS-1:0]    x_frac_mag;
  logic [IP_W-1:0]         x_len;
  logic [POS_W-1:0]        x_len_pos;
  logic                    x_over;
  logic                    x_under;
  logic                    x_go;
  logic                    x_stop;
  logic [IP_W-1:0]         x_ip;
  logic signed [R_W-1:0]   x_r;
  logic [IDX_W-1:0]        x_idx_a;
  logic [IDX_W-1:0]        x_idx_b;
  logic                    x_sound;
  logic                    x_va;
  logic                    x_vb;
  logic                    x_fin;
  logic                    mem_we;

  logic [SAMPLE_W-1:0]     sample_mem [0:STORE_DEPTH-1];
  logic [SAMPLE_W-1:0]     rd_a_r;
  logic [SAMPLE_W-1:0]     rd_b_r;

  logic                    y_vld_r;
  logic                    y_va_r;
  logic                    y_vb_r;
  logic signed [R_W-1:0]   y_r_r;
  logic                    y_play_r;
  logic                    y_fin_r;
  logic                    y_adv;
  logic                    y_free;
  logic signed [SAMPLE_W-1:0] y_a;
  logic signed [SAMPLE_W-1:0] y_b;
  logic signed [DIFF_W-1:0]   y_diff;

  logic                       z_vld_r;
  logic signed [SAMPLE_W-1:0] z_a_r;
  logic signed [PROD_W-1:0]   z_prod_r;
  logic                       z_play_r;
  logic                       z_fin_r;
  logic                       z_adv;
  logic                       z_free;
  logic signed [ACC_W-1:0]    z_acc;
  logic signed [ACC_W-1:0]    z_rnd;
  logic signed [QT_W-1:0]     z_q;
  logic [SAMPLE_W-1:0]        z_sat;

  logic                    o_vld_r;
  logic [SAMPLE_W-1:0]     o_sample_r;
  logic                    o_play_r;
  logic                    o_fin_r;
  logic                    o_free;

  // Pipeline flow control, output side first.
  assign o_free = !o_vld_r || out_ch.ready;
  assign z_adv  = z_vld_r && o_free;
  assign z_free = !z_vld_r || z_adv;
  assign y_adv  = y_vld_r && z_free;
  assign y_free = !y_vld_r || y_adv;
  assign x_fire = x_vld_r && y_free;
  // The issue stage loads only when empty, so each item sees the position
  // left by the one before it.
  assign q_pop  = q_vld && !x_vld_r;

  always_comb begin
    x_neg      = x_sum_r[POS_W-1];
    x_mag      = x_neg ? POS_W'(-x_sum_r) : POS_W'(x_sum_r);
    x_ip_mag   = x_mag[POS_W-1:FRAC_BITS];
    x_frac_mag = x_mag[FRAC_BITS-1:0];
    x_len      = IP_W'(cfg.sample_count);
    x_len_pos  = POS_W'({cfg.sample_count, FRAC_BITS'(0)});
    x_over     = !x_neg && (x_ip_mag > x_len);
    x_under    = x_neg && (x_ip_mag != '0);
    x_go       = playing_r && !paused_r && cfg.loaded;
    x_stop     = (x_over || x_under) && !cfg.looping;
    if (x_over) begin
      x_ip = '0;
    end else if (x_under) begin
      x_ip = x_len;
    end else if (x_neg) begin
      x_ip = '0;
    end else begin
      x_ip = x_ip_mag;
    end
    // The fraction is signed and taken before any wrap.
    x_r     = x_neg ? -R_W'(x_frac_mag) : R_W'(x_frac_mag);
    x_idx_a = IDX_W'(x_ip) + IDX_W'(1);
    x_idx_b = IDX_W'(x_ip) + IDX_W'(2);
    x_sound = (x_item_r.cmd == CMD_TICK) && x_go && !x_stop;
    x_va    = x_sound && (x_idx_a < IDX_W'(cfg.sample_count))
              && (32'(x_idx_a) < STORE_DEPTH);
    x_vb    = x_sound && (x_idx_b < IDX_W'(cfg.sample_count))
              && (32'(x_idx_b) < STORE_DEPTH);

    pos_nxt     = pos_r;
    playing_nxt = playing_r;
    paused_nxt  = paused_r;
    x_fin       = 1'b0;
    mem_we      = 1'b0;
    case (x_item_r.cmd)
      CMD_TICK: begin
        if (x_go) begin
          if (x_over && cfg.looping) begin
            pos_nxt = '0;
          end else if (x_under && cfg.looping) begin
            pos_nxt = x_len_pos;
          end else begin
            pos_nxt = x_sum_r;
          end
          if (x_stop) begin
            playing_nxt = 1'b0;
            x_fin       = 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        mem_we = (32'(x_item_r.address) < STORE_DEPTH);
      end
      CMD_PLAY: begin
        pos_nxt     = (signed'(cfg.speed) > 0) ? '0 : x_len_pos;
        playing_nxt = 1'b1;
      end
      CMD_STOP: begin
        pos_nxt     = '0;
        playing_nxt = 1'b0;
        paused_nxt  = 1'b0;
      end
      CMD_PAUSE: begin
        paused_nxt = x_item_r.pause_on;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      playing_r <= 1'b0;
      paused_r  <= 1'b0;
      x_vld_r   <= 1'b0;
      y_vld_r   <= 1'b0;
      z_vld_r   <= 1'b0;
      o_vld_r   <= 1'b0;
    end else begin
      if (x_fire) begin
        pos_r     <= pos_nxt;
        playing_r <= playing_nxt;
        paused_r  <= paused_nxt;
      end
      if (q_pop) begin
        x_vld_r <= 1'b1;
      end else if (x_fire) begin
        x_vld_r <= 1'b0;
      end
      if (x_fire) begin
        y_vld_r <= 1'b1;
      end else if (y_adv) begin
        y_vld_r <= 1'b0;
      end
      if (y_adv) begin
        z_vld_r <= 1'b1;
      end else if (z_adv) begin
        z_vld_r <= 1'b0;
      end
      if (z_adv) begin
        o_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_item_r <= q_item;
      x_sum_r  <= pos_r + POS_W'(signed'(cfg.speed));
    end
    if (x_fire) begin
      y_va_r   <= x_va;
      y_vb_r   <= x_vb;
      y_r_r    <= x_r;
      y_play_r <= playing_nxt;
      y_fin_r  <= x_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire && mem_we) begin
      sample_mem[MEM_AW'(x_item_r.address)] <= x_item_r.sample_data;
    end
    if (x_fire) begin
      rd_a_r <= sample_mem[MEM_AW'(x_idx_a)];
      rd_b_r <= sample_mem[MEM_AW'(x_idx_b)];
    end
  end

  // Interpolation as a + r * (b - a), with a carrying the fraction scale.
  always_comb begin
    y_a    = y_va_r ? signed'(rd_a_r) : '0;
    y_b    = y_vb_r ? signed'(rd_b_r) : '0;
    y_diff = DIFF_W'(y_b) - DIFF_W'(y_a);
  end

  always_ff @(posedge clk) begin
    if (y_adv) begin
      z_a_r    <= y_a;
      z_prod_r <= y_r_r * y_diff;
      z_play_r <= y_play_r;
      z_fin_r  <= y_fin_r;
    end
  end

  // Round half away from zero, then saturate to the sample range.
  always_comb begin
    z_acc = (ACC_W'(z_a_r) <<< FRAC_BITS) + ACC_W'(z_prod_r);
    z_rnd = z_acc + HALF - ACC_W'(z_acc[ACC_W-1]);
    z_q   = QT_W'(z_rnd >>> FRAC_BITS);
    if (z_q > QT_HI) begin
      z_sat = SAMPLE_W'(QT_HI);
    end else if (z_q < QT_LO) begin
      z_sat = SAMPLE_W'(QT_LO);
    end else begin
      z_sat = z_q[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (z_adv) begin
      o_sample_r <= z_sat;
      o_play_r   <= z_play_r;
      o_fin_r    <= z_fin_r;
    end
  end

  assign out_ch.valid      = o_vld_r;
  assign out_ch.sample_out = o_sample_r;
  assign out_ch.playing    = o_play_r;
  assign out_ch.finished   = o_fin_r;

  a_fin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_fin_r |-> o_sample_r == '0 && !o_play_r)
    else $error("Finished item carries a sample or a playing flag.");

  a_issue_gap: assert property (@(posedge clk) disable iff (!rst_n)
    x_fire |=> !x_vld_r)
    else $error("Issue stage reloaded in the cycle after an item left.");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    x_fire && x_item_r.cmd == CMD_STOP |=> pos_r == '0 && !playing_r && !paused_r)
    else $error("Stop did not clear position and play state.");

endmodule

// ===== sv/variable_rate_sample_player_top.sv =====
// ----------------------------------------------------------------------------
// variable_rate_sample_player_top
// Variable-speed sample player with linear interpolation between stored
// 16-bit samples, controlled by request items and an APB register port.
//
//   Channel   Direction  Handshake            Carries
//   in_ch     sink       valid/ready          req_type, address, sample_data,
//                                             pause_on
//   out_ch    source     valid/ready          sample_out, playing, finished
//   APB       slave      psel/penable/pready  speed, looping, sample_count,
//                                             loaded
//
// The issue stage holds one item at a time and takes a new one only after
// the last has left; it updates position and play state as the item moves on
// to the store read. A result passes the queue, issue, store read, multiply
// and output registers in turn and leaves at the first edge with out_ch ready.
// A 4-entry queue accepts items until full while the engine or output stalls.
// rst_n is synchronous; the sample store is not cleared and is undefined
// until written.
// ----------------------------------------------------------------------------
module variable_rate_sample_player_top import vrsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vrsp_in_if.sink           in_ch,
  vrsp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  logic  q_vld;
  item_t q_item;
  logic  q_pop;

  vrsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vrsp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  vrsp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
